### src/ssmt_pkg.sv
// Shared types and constants for the skyline sweep max tracker.
package ssmt_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int LABEL_BITS  = 8;

   // Edge event codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_END   = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LEAF  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_MERGE = 7'b0001000,
      S_FINAL = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_CLEAR = 7'b1000000
   } state_type;

endpackage

### src/skyline_sweep_max_tracker.sv
// Skyline sweep: tracks the max active building height with a max tree in RAM.
//
// Usage: edge events, sorted by x, enter on the req_ channel (valid/ready).
// A start event sets a label's height, an end event drops the label. When x
// moves to a new group, or at the event flagged last_event, the block sends
// (x, height) on the rsp_ channel if the skyline height changed; rsp_last
// marks the final result of one event. A sweep starting at x > 0 first
// reports (0, 0). Each event yields zero, one or two results.
//
// Timing: the running max lives in a max tree (one leaf per label, each node
// the max of its two children) held in a single-port-write, single-port-read
// RAM. An event rewrites its leaf and walks one compare unit up the tree,
// with a read state and a merge state per level; each result is then
// handed to the output register. req_ready is low while an event is in work.
//
// Reset, and the end of every sweep, start a clearing pass that writes zero
// to all 2*2^clog2(MAX_BUILDINGS) tree nodes, one per cycle (512 for 256
// labels); no event is taken meanwhile. A stalled receiver holds the result
// in the output register; the sequencer waits for it only when it has
// another result to send.
module skyline_sweep_max_tracker
   import ssmt_pkg::*;
#(
   parameter int MAX_BUILDINGS = 256,
   parameter int COORD_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [COORD_BITS-1:0]  req_x,
   input  logic [HEIGHT_BITS-1:0] req_height,
   input  logic [LABEL_BITS-1:0]  req_label,
   input  logic                   req_last_event,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_BITS-1:0]  rsp_point_x,
   output logic [HEIGHT_BITS-1:0] rsp_point_height,
   output logic                   rsp_last
);

   localparam int LEAF_BITS = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;
   localparam int IDX_BITS  = LEAF_BITS + 1;
   localparam int NODES     = 1 << IDX_BITS;

   // Max tree storage
   logic [HEIGHT_BITS-1:0] tree_mem [0:NODES-1];
   logic [HEIGHT_BITS-1:0] rd_ff;
   logic                   we;
   logic [IDX_BITS-1:0]    waddr;
   logic [IDX_BITS-1:0]    raddr;
   logic [HEIGHT_BITS-1:0] wdata;

   state_type state_ff, state_in;

   // Latched event
   logic                   op_ff, op_in;
   logic [COORD_BITS-1:0]  x_ff, x_in;
   logic [HEIGHT_BITS-1:0] h_ff, h_in;
   logic [LEAF_BITS-1:0]   leaf_ff, leaf_in;
   logic                   fin_ff, fin_in;

   // Sweep state
   logic [HEIGHT_BITS-1:0] max_ff, max_in;
   logic [HEIGHT_BITS-1:0] prev_ff, prev_in;
   logic [COORD_BITS-1:0]  pend_x_ff, pend_x_in;
   logic                   seen_ff, seen_in;

   // Tree walk
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [HEIGHT_BITS-1:0] cur_ff, cur_in;
   logic [IDX_BITS-1:0]    clr_ff, clr_in;

   // Results waiting for the output register
   logic                   pend0_v_ff, pend0_v_in;
   logic [COORD_BITS-1:0]  pend0_x_ff, pend0_x_in;
   logic [HEIGHT_BITS-1:0] pend0_h_ff, pend0_h_in;
   logic                   pend1_v_ff, pend1_v_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  rsp_x_ff, rsp_x_in;
   logic [HEIGHT_BITS-1:0] rsp_h_ff, rsp_h_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   in_range;
   logic                   out_free;
   logic [HEIGHT_BITS-1:0] merged;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_x      = rsp_x_ff;
   assign rsp_point_height = rsp_h_ff;
   assign rsp_last         = rsp_last_ff;

   assign in_range = (32'(req_label) < MAX_BUILDINGS);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign merged   = (cur_ff > rd_ff) ? cur_ff : rd_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      h_in         = h_ff;
      leaf_in      = leaf_ff;
      fin_in       = fin_ff;
      max_in       = max_ff;
      prev_in      = prev_ff;
      pend_x_in    = pend_x_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      pend0_v_in   = pend0_v_ff;
      pend0_x_in   = pend0_x_ff;
      pend0_h_in   = pend0_h_ff;
      pend1_v_in   = pend1_v_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_last_in  = rsp_last_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      raddr        = idx_ff ^ IDX_BITS'(1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               x_in       = req_x;
               h_in       = req_height;
               leaf_in    = LEAF_BITS'(req_label);
               fin_in     = req_last_event;
               pend0_v_in = 1'b0;
               pend1_v_in = 1'b0;
               // opening point, or close of the previous x group
               if (!seen_ff) begin
                  if (req_x != '0) begin
                     pend0_v_in = 1'b1;
                     pend0_x_in = '0;
                     pend0_h_in = '0;
                  end
               end else if (req_x != pend_x_ff && max_ff != prev_ff) begin
                  pend0_v_in = 1'b1;
                  pend0_x_in = pend_x_ff;
                  pend0_h_in = max_ff;
                  prev_in    = max_ff;
               end
               seen_in   = 1'b1;
               pend_x_in = req_x;
               state_in  = in_range ? S_LEAF : S_FINAL;
            end
         end
         S_LEAF: begin
            we       = 1'b1;
            waddr    = {1'b1, leaf_ff};
            wdata    = (op_ff == OP_START) ? h_ff : '0;
            cur_in   = wdata;
            idx_in   = waddr;
            state_in = S_READ;
         end
         S_READ: begin
            // sibling read issued here; root reached ends the walk
            if (idx_ff == IDX_BITS'(1)) begin
               max_in   = cur_ff;
               state_in = S_FINAL;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            we       = 1'b1;
            waddr    = idx_ff >> 1;
            wdata    = merged;
            cur_in   = merged;
            idx_in   = idx_ff >> 1;
            state_in = S_READ;
         end
         S_FINAL: begin
            if (fin_ff && max_ff != prev_ff) begin
               pend1_v_in = 1'b1;
               prev_in    = max_ff;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (pend0_v_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = pend0_x_ff;
                  rsp_h_in     = pend0_h_ff;
                  rsp_last_in  = !pend1_v_ff;
                  pend0_v_in   = 1'b0;
               end
            end else if (pend1_v_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = x_ff;
                  rsp_h_in     = max_ff;
                  rsp_last_in  = 1'b1;
                  pend1_v_in   = 1'b0;
               end
            end else if (fin_ff) begin
               // sweep over: back to reset state
               max_in    = '0;
               prev_in   = '0;
               pend_x_in = '0;
               seen_in   = 1'b0;
               clr_in    = '0;
               state_in  = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + IDX_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Tree RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         tree_mem[waddr] <= wdata;
      end
      rd_ff <= tree_mem[raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         max_ff       <= '0;
         prev_ff      <= '0;
         pend_x_ff    <= '0;
         seen_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         pend0_v_ff   <= 1'b0;
         pend1_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         max_ff       <= max_in;
         prev_ff      <= prev_in;
         pend_x_ff    <= pend_x_in;
         seen_ff      <= seen_in;
         fin_ff       <= fin_in;
         pend0_v_ff   <= pend0_v_in;
         pend1_v_ff   <= pend1_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      x_ff       <= x_in;
      h_ff       <= h_in;
      leaf_ff    <= leaf_in;
      idx_ff     <= idx_in;
      cur_ff     <= cur_in;
      pend0_x_ff <= pend0_x_in;
      pend0_h_ff <= pend0_h_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // walk never drops below the root
   a_idx_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (idx_ff != '0))
      else $error("tree walk index reached zero");

   // root value becomes the running max
   a_root_to_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && idx_ff == IDX_BITS'(1)) |=> (max_ff == $past(cur_ff)))
      else $error("running max not taken from tree root");

   // sweep state is cleared throughout the clearing pass
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (prev_ff == '0 && max_ff == '0 && !seen_ff))
      else $error("sweep state not cleared during clearing pass");

   // a final point only comes from a last event
   a_final_needs_fin: assert property (@(posedge clock) disable iff (reset)
      pend1_v_ff |-> fin_ff)
      else $error("final point pending without last event");
`endif

endmodule
